// ===== rtl/rdb_pkg.sv =====
// ----------------------------------------------------------------------------
// rdb_pkg
// Shared types and constants for the reversible deque buffer: store depth,
// derived widths, operation codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package rdb_pkg;

	// Depth of the circular byte store.
	localparam int unsigned DEPTH = 1024;

	// Field widths fixed by the interface.
	localparam int unsigned MODE_W = 2;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned POS_W  = 10;
	localparam int unsigned FILL_W = 11;

	// Widths that follow from the depth.
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	// Common width for comparing and reporting the fill level.
	localparam int unsigned WIDE_W_A = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int unsigned WIDE_W   = (WIDE_W_A > FILL_W) ? WIDE_W_A : FILL_W;

	// Operation codes carried on the mode field.
	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	// Side codes for a push.
	localparam logic SIDE_FRONT = 1'b0;
	localparam logic SIDE_BACK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} rdb_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic respond;
	} rdb_cmd_t;

endpackage

// ===== rtl/rdb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdb_ctrl
// Sequencer for the reversible deque buffer: capture, execute, respond.
// ----------------------------------------------------------------------------
module rdb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output rdb_pkg::rdb_cmd_t cmd
);

	rdb_pkg::rdb_state_t state_q;
	rdb_pkg::rdb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rdb_pkg::ST_IDLE: begin
				if (start) begin
					state_d = rdb_pkg::ST_EXEC;
				end
			end
			rdb_pkg::ST_EXEC: begin
				state_d = rdb_pkg::ST_RESP;
			end
			rdb_pkg::ST_RESP: begin
				state_d = rdb_pkg::ST_IDLE;
			end
			default: begin
				state_d = rdb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = (state_q != rdb_pkg::ST_IDLE);
		cmd.capture = (state_q == rdb_pkg::ST_IDLE) && start;
		cmd.exec    = (state_q == rdb_pkg::ST_EXEC);
		cmd.respond = (state_q == rdb_pkg::ST_RESP);
	end

endmodule

// ===== rtl/rdb_datapath.sv =====
// ----------------------------------------------------------------------------
// rdb_datapath
// Byte store, head pointer, fill count and reverse flag, with the address
// mapping from logical sides and positions onto physical entries.
// ----------------------------------------------------------------------------
module rdb_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rdb_pkg::rdb_cmd_t            cmd,
	input  logic [rdb_pkg::MODE_W-1:0]   mode,
	input  logic                         side,
	input  logic [rdb_pkg::DATA_W-1:0]   data_byte,
	input  logic [rdb_pkg::POS_W-1:0]    position,
	output logic [rdb_pkg::DATA_W-1:0]   read_byte,
	output logic [rdb_pkg::FILL_W-1:0]   fill_count,
	output logic                         reversed,
	output logic                         error
);

	localparam int unsigned AW = rdb_pkg::ADDR_W;
	localparam int unsigned CW = rdb_pkg::CNT_W;
	localparam int unsigned WW = rdb_pkg::WIDE_W;

	logic [rdb_pkg::DATA_W-1:0] mem [rdb_pkg::DEPTH];

	// Captured item.
	logic [rdb_pkg::MODE_W-1:0] mode_q;
	logic                       side_q;
	logic [rdb_pkg::DATA_W-1:0] data_q;
	logic [rdb_pkg::POS_W-1:0]  pos_q;

	// Architectural state.
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          rev_q;

	// Result registers.
	logic [rdb_pkg::DATA_W-1:0] rd_q;
	logic                       rd_ok_q;
	logic                       err_q;

	// Combinational execution results.
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_d;
	logic          rev_d;
	logic          err_d;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] addr;
	logic [CW-1:0] off;
	logic [AW:0]   sum;
	logic          full;
	logic          beyond;
	logic [AW-1:0] head_dec;

	always_comb begin
		full     = (count_q == CW'(rdb_pkg::DEPTH));
		beyond   = (WW'(pos_q) >= WW'(count_q));
		head_dec = (head_q == '0) ? AW'(rdb_pkg::DEPTH - 1) : head_q - AW'(1);

		// Offset from the head: the fill count for a back push, the logical
		// position (mirrored when reversed) for a read.
		if (mode_q == rdb_pkg::MODE_PUSH) begin
			off = count_q;
		end else if (rev_q) begin
			off = count_q - CW'(1) - CW'(pos_q);
		end else begin
			off = CW'(pos_q);
		end
		sum = (AW + 1)'(head_q) + (AW + 1)'(off);
		if (sum >= (AW + 1)'(rdb_pkg::DEPTH)) begin
			sum = sum - (AW + 1)'(rdb_pkg::DEPTH);
		end

		head_d  = head_q;
		count_d = count_q;
		rev_d   = rev_q;
		err_d   = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		addr    = sum[AW-1:0];

		unique case (mode_q)
			rdb_pkg::MODE_PUSH: begin
				if (full) begin
					err_d = 1'b1;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + CW'(1);
					if ((side_q ^ rev_q) == rdb_pkg::SIDE_FRONT) begin
						head_d = head_dec;
						addr   = head_dec;
					end
				end
			end
			rdb_pkg::MODE_TOGGLE: begin
				rev_d = ~rev_q;
			end
			rdb_pkg::MODE_READ: begin
				if (beyond) begin
					err_d = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
				err_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			side_q <= side;
			data_q <= data_byte;
			pos_q  <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			rd_ok_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
			rev_q   <= rev_d;
			rd_ok_q <= rd_en;
			err_q   <= err_d;
		end
	end

	// Store: one write or one registered read per executed item.
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[addr] <= data_q;
		end
		if (cmd.exec && rd_en) begin
			rd_q <= mem[addr];
		end
	end

	logic [WW-1:0] count_wide;

	always_comb begin
		count_wide = WW'(count_q);
		read_byte  = (cmd.respond && rd_ok_q) ? rd_q : '0;
		fill_count = count_wide[rdb_pkg::FILL_W-1:0];
		reversed   = rev_q;
		error      = err_q;
	end

endmodule

// ===== rtl/reversible_deque_buffer_top.sv =====
// ----------------------------------------------------------------------------
// reversible_deque_buffer_top
// Byte deque in a circular store with a constant-time logical reverse flag.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Signals
//   -------   ----------------   ---------------------------------------------
//   command   start / busy       mode, side, data_byte, position
//   result    done (one cycle)   read_byte, fill_count, reversed, error
//
// Each item passes through capture, execute and respond in that order. The
// sequence is set by the single-port store, whose read data is registered
// before it is presented, and by the controller holding one item at a time;
// a new transfer is taken in the cycle after done.
// Reset clears the head pointer, fill count and reverse flag at once; the
// store contents are undefined until pushed, and no clearing pass is run.
// The receiver cannot stall: the result is shown for exactly the done cycle.
// ----------------------------------------------------------------------------
module reversible_deque_buffer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rdb_pkg::MODE_W-1:0]  mode,
	input  logic                        side,
	input  logic [rdb_pkg::DATA_W-1:0]  data_byte,
	input  logic [rdb_pkg::POS_W-1:0]   position,
	output logic                        done,
	output logic [rdb_pkg::DATA_W-1:0]  read_byte,
	output logic [rdb_pkg::FILL_W-1:0]  fill_count,
	output logic                        reversed,
	output logic                        error
);

	// Commands from the sequencer: capture latches the item on an accepted
	// transfer, exec performs the store access and pointer update, and
	// respond marks the cycle in which the result is valid.
	rdb_pkg::rdb_cmd_t cmd;

	rdb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath keeps the head pointer at the physical front; a push at
	// the logical front goes to the head when the flag is clear and to the
	// tail when it is set, and reads mirror the position likewise.
	rdb_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.side       (side),
		.data_byte  (data_byte),
		.position   (position),
		.read_byte  (read_byte),
		.fill_count (fill_count),
		.reversed   (reversed),
		.error      (error)
	);

	// The result strobe is the respond command itself.
	assign done = cmd.respond;

endmodule

// ===== rtl/rdb_checker.sv =====
// ----------------------------------------------------------------------------
// rdb_checker
// Port-level assertions for the reversible deque buffer, bound to the top.
// ----------------------------------------------------------------------------
module rdb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [rdb_pkg::MODE_W-1:0]  mode,
	input logic                        done,
	input logic [rdb_pkg::DATA_W-1:0]  read_byte,
	input logic [rdb_pkg::FILL_W-1:0]  fill_count,
	input logic                        reversed,
	input logic                        error
);

	// An accepted transfer yields its result after the execute state, in the respond state.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing after accepted transfer");

	// A result is only shown while the block is busy with its item.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	// A toggle item flips the reported flag.
	a_toggle_flips: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == rdb_pkg::MODE_TOGGLE)) |-> ##2
		(done && (reversed != $past(reversed, 2))))
		else $error("toggle did not flip the reverse flag");

	// A flagged result never carries a byte.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (read_byte == '0))
		else $error("error result carries a non-zero byte");

	// The fill level never exceeds the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (fill_count <= rdb_pkg::FILL_W'(rdb_pkg::DEPTH)))
		else $error("fill level beyond store depth");

endmodule

bind reversible_deque_buffer_top rdb_checker u_rdb_checker (.*);
